/* hw/rtl/priq_pkg.sv */
package priq_pkg;

   // fixed field widths of the channels
   localparam int IndexBits   = 5;
   localparam int PrioReqBits = 8;
   localparam int OccBits     = 6;
   localparam int KindBits    = 3;
   localparam int StatusBits  = 2;

   typedef logic [KindBits-1:0]   kind_type;
   typedef logic [StatusBits-1:0] rsp_status_type;

   localparam kind_type KindInsert      = 3'd0;
   localparam kind_type KindRemoveHead  = 3'd1;
   localparam kind_type KindRemoveIndex = 3'd2;
   localparam kind_type KindPeek        = 3'd3;
   localparam kind_type KindClear       = 3'd4;

   localparam rsp_status_type StatusOk   = 2'd0;
   localparam rsp_status_type StatusMiss = 2'd1;
   localparam rsp_status_type StatusFull = 2'd2;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      DpIdle,
      DpStart,
      DpRead,
      DpInsert,
      DpRemove,
      DpHead,
      DpShort,
      DpEmit
   } dp_op_type;

   typedef struct packed {
      logic      latch;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     empty;
      logic     full;
      logic     lower;
      logic     hit;
      logic     ptr_first;
      logic     ptr_last;
      logic     out_free;
   } dp_status_type;

endpackage

/* hw/rtl/priq_if.sv */
interface priq_req_if;
   import priq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KindBits-1:0]    kind;
   logic [IndexBits-1:0]   entry_index;
   logic [PrioReqBits-1:0] priority_req;

   modport source (output valid, kind, entry_index, priority_req, input ready);
   modport sink   (input valid, kind, entry_index, priority_req, output ready);
endinterface

interface priq_rsp_if;
   import priq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [StatusBits-1:0]  status;
   logic [IndexBits-1:0]   out_index;
   logic [PrioReqBits-1:0] out_priority;
   logic [OccBits-1:0]     occupancy;
   logic                   is_empty;

   modport source (output valid, status, out_index, out_priority, occupancy, is_empty,
                   input ready);
   modport sink   (input valid, status, out_index, out_priority, occupancy, is_empty,
                   output ready);
endinterface

/* hw/rtl/priority_sorted_queue.sv */
// Channel   Dir  Modport  Payload
// req_chan  in   sink     kind, entry_index, priority_req
// rsp_chan  out  source   status, out_index, out_priority, occupancy, is_empty
//
// One operation at a time. Each stored entry visited takes a registered
// read of the slot RAM, then a compare and shifting write back. Insert walks
// from the tail, moving lower entries toward the tail, and writes slot 0 when
// the new entry lands at the head; remove visits every entry, peek slot 0
// only, and full/empty/clear skip the walk; any wait on rsp_chan.ready follows.
// Reset clears the count, found flag and output valid; slots past it are never read.
// A finished result sits in the output register while the next request
// transfers; a stalled output holds the block only at the end of that request.
module priority_sorted_queue #(
   parameter int QUEUE_DEPTH = 32,
   parameter int PRIO_BITS   = 8
) (
   input logic         clock,
   input logic         reset,
   priq_req_if.sink    req_chan,
   priq_rsp_if.source  rsp_chan
);
   import priq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   priq_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   priq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .PRIO_BITS(PRIO_BITS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_chan.kind),
      .req_entry_index  (req_chan.entry_index),
      .req_priority_req (req_chan.priority_req),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_out_index    (rsp_chan.out_index),
      .rsp_out_priority (rsp_chan.out_priority),
      .rsp_occupancy    (rsp_chan.occupancy),
      .rsp_is_empty     (rsp_chan.is_empty)
   );

`ifndef ASSERT_OFF
   // a request transfer closes the input until the result is staged
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in progress");

   a_error_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != StatusOk) |->
      (rsp_chan.out_index == '0 && rsp_chan.out_priority == '0))
      else $error("error result carries a nonzero index or priority");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == StatusFull) |-> !rsp_chan.is_empty)
      else $error("full refusal reported with an empty queue");
`endif

endmodule

/* hw/rtl/priq_ram.sv */
module priq_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/priq_datapath.sv */
module priq_datapath #(
   parameter int QUEUE_DEPTH = 32,
   parameter int PRIO_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  priq_pkg::dp_cmd_type                cmd,
   output priq_pkg::dp_status_type             stat,
   input  logic [priq_pkg::KindBits-1:0]       req_kind,
   input  logic [priq_pkg::IndexBits-1:0]      req_entry_index,
   input  logic [priq_pkg::PrioReqBits-1:0]    req_priority_req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [priq_pkg::StatusBits-1:0]     rsp_status,
   output logic [priq_pkg::IndexBits-1:0]      rsp_out_index,
   output logic [priq_pkg::PrioReqBits-1:0]    rsp_out_priority,
   output logic [priq_pkg::OccBits-1:0]        rsp_occupancy,
   output logic                                rsp_is_empty
);
   import priq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = IndexBits + PRIO_BITS;
   localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

   function automatic logic [PrioReqBits-1:0] prio_out(input logic [PRIO_BITS-1:0] p);
      logic [PRIO_BITS+PrioReqBits-1:0] w;
      w = {{PrioReqBits{1'b0}}, p};
      return w[PrioReqBits-1:0];
   endfunction

   function automatic logic [PRIO_BITS-1:0] prio_in(input logic [PrioReqBits-1:0] p);
      logic [PRIO_BITS+PrioReqBits-1:0] w;
      w = {{PRIO_BITS{1'b0}}, p};
      return w[PRIO_BITS-1:0];
   endfunction

   kind_type                kind_ff, kind_in;
   logic [IndexBits-1:0]    idx_ff, idx_in;
   logic [PRIO_BITS-1:0]    prio_ff, prio_in_v;
   logic [CW-1:0]           fill_ff, fill_in, fill_dec;
   logic [AW-1:0]           ptr_ff, ptr_in, last_ff, last_in;
   logic                    found_ff, found_in;
   rsp_status_type          res_status_ff, res_status_in;
   logic [IndexBits-1:0]    res_index_ff, res_index_in;
   logic [PrioReqBits-1:0]  res_prio_ff, res_prio_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_status_type          rsp_status_ff, rsp_status_in;
   logic [IndexBits-1:0]    rsp_index_ff, rsp_index_in;
   logic [PrioReqBits-1:0]  rsp_prio_ff, rsp_prio_in;
   logic [OccBits-1:0]      rsp_occ_ff, rsp_occ_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [CW+OccBits-1:0]   fill_wide;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data, rd_data, new_entry;
   logic [IndexBits-1:0] rd_idx;
   logic [PRIO_BITS-1:0] rd_prio;

   priq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign rd_idx    = rd_data[EW-1:PRIO_BITS];
   assign rd_prio   = rd_data[PRIO_BITS-1:0];
   assign new_entry = {idx_ff, prio_ff};
   assign fill_dec  = fill_ff - CW'(1);
   assign fill_wide = {{OccBits{1'b0}}, fill_ff};

   always_comb begin
      stat.kind      = kind_ff;
      stat.empty     = (fill_ff == '0);
      stat.full      = (fill_ff == FullCount);
      stat.lower     = (rd_prio < prio_ff);
      // head and peek take slot 0; remove by index takes the first match
      stat.hit       = !found_ff && ((kind_ff != KindRemoveIndex) || (rd_idx == idx_ff));
      stat.ptr_first = (ptr_ff == '0);
      stat.ptr_last  = (ptr_ff == last_ff);
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      prio_in_v     = prio_ff;
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      last_in       = last_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_prio_in   = res_prio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = rd_data;

      if (cmd.latch) begin
         kind_in   = req_kind;
         idx_in    = req_entry_index;
         prio_in_v = prio_in(req_priority_req);
      end

      unique case (cmd.op)
         DpIdle: begin
         end
         DpStart: begin
            last_in       = fill_dec[AW-1:0];
            ptr_in        = (kind_ff == KindInsert) ? fill_dec[AW-1:0] : '0;
            found_in      = 1'b0;
            res_status_in = StatusOk;
            res_index_in  = '0;
            res_prio_in   = '0;
         end
         DpRead: begin
            rd_en = 1'b1;
         end
         DpInsert: begin
            // walk from the tail, moving strictly lower entries down one slot
            wr_en   = 1'b1;
            wr_addr = ptr_ff + AW'(1);
            if (stat.lower) begin
               if (!stat.ptr_first) begin
                  ptr_in = ptr_ff - AW'(1);
               end
            end else begin
               wr_data       = new_entry;
               fill_in       = fill_ff + CW'(1);
               res_status_in = StatusOk;
               res_index_in  = idx_ff;
               res_prio_in   = prio_out(prio_ff);
            end
         end
         DpRemove: begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff - AW'(1);
            end
            if (stat.hit) begin
               found_in     = 1'b1;
               res_index_in = rd_idx;
               res_prio_in  = prio_out(rd_prio);
            end
            if (kind_ff == KindPeek && stat.hit) begin
               res_status_in = StatusOk;
            end else if (stat.ptr_last) begin
               if (found_ff || stat.hit) begin
                  fill_in = fill_dec;
               end else begin
                  res_status_in = StatusMiss;
               end
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         DpHead: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data       = new_entry;
            fill_in       = fill_ff + CW'(1);
            res_status_in = StatusOk;
            res_index_in  = idx_ff;
            res_prio_in   = prio_out(prio_ff);
         end
         DpShort: begin
            res_index_in = '0;
            res_prio_in  = '0;
            priority if (kind_ff == KindInsert) begin
               res_status_in = StatusFull;
            end else if (kind_ff == KindRemoveHead || kind_ff == KindRemoveIndex ||
                         kind_ff == KindPeek) begin
               res_status_in = StatusMiss;
            end else if (kind_ff == KindClear) begin
               res_status_in = StatusOk;
               fill_in       = '0;
            end else begin
               res_status_in = StatusOk;
            end
         end
         DpEmit: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_index_in  = res_index_ff;
            rsp_prio_in   = res_prio_ff;
            rsp_occ_in    = fill_wide[OccBits-1:0];
            rsp_empty_in  = (fill_ff == '0);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      prio_ff       <= prio_in_v;
      ptr_ff        <= ptr_in;
      last_ff       <= last_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_prio_ff   <= res_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_index    = rsp_index_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_is_empty     = rsp_empty_ff;

endmodule

/* hw/rtl/priq_control.sv */
module priq_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  priq_pkg::dp_status_type stat,
   output priq_pkg::dp_cmd_type    cmd
);
   import priq_pkg::*;

   localparam logic [2:0] SIdle     = 3'd0;
   localparam logic [2:0] SDispatch = 3'd1;
   localparam logic [2:0] SRead     = 3'd2;
   localparam logic [2:0] SEval     = 3'd3;
   localparam logic [2:0] SHead     = 3'd4;
   localparam logic [2:0] SDone     = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.latch = 1'b0;
      cmd.op    = DpIdle;

      unique case (state_ff)
         SIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = SDispatch;
            end
         end
         SDispatch: begin
            priority if (stat.kind == KindInsert) begin
               if (stat.full) begin
                  cmd.op   = DpShort;
                  state_in = SDone;
               end else if (stat.empty) begin
                  state_in = SHead;
               end else begin
                  cmd.op   = DpStart;
                  state_in = SRead;
               end
            end else if (stat.kind == KindRemoveHead || stat.kind == KindRemoveIndex ||
                         stat.kind == KindPeek) begin
               if (stat.empty) begin
                  cmd.op   = DpShort;
                  state_in = SDone;
               end else begin
                  cmd.op   = DpStart;
                  state_in = SRead;
               end
            end else begin
               cmd.op   = DpShort;
               state_in = SDone;
            end
         end
         SRead: begin
            cmd.op   = DpRead;
            state_in = SEval;
         end
         SEval: begin
            if (stat.kind == KindInsert) begin
               cmd.op = DpInsert;
               if (!stat.lower) begin
                  state_in = SDone;
               end else if (stat.ptr_first) begin
                  state_in = SHead;
               end else begin
                  state_in = SRead;
               end
            end else begin
               cmd.op = DpRemove;
               if ((stat.kind == KindPeek && stat.hit) || stat.ptr_last) begin
                  state_in = SDone;
               end else begin
                  state_in = SRead;
               end
            end
         end
         SHead: begin
            cmd.op   = DpHead;
            state_in = SDone;
         end
         SDone: begin
            if (stat.out_free) begin
               cmd.op   = DpEmit;
               state_in = SIdle;
            end
         end
         default: begin
            state_in = SIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
